// ----- design/flow_controlled_byte_fifo_top_defines.svh -----
// Assertion macros shared by the byte FIFO design files.
// Include after the module's clock and reset are in scope (clk_i, rst_ni).
`ifndef FLOW_CONTROLLED_BYTE_FIFO_TOP_DEFINES_SVH
`define FLOW_CONTROLLED_BYTE_FIFO_TOP_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset
`define FCBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property checked in the cycle after its trigger
`define FCBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FCBF_ASSERT(lbl, prop, msg)

`define FCBF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- design/fcbf_pkg.sv -----
// Package for the flow-controlled byte FIFO: field widths, defaults,
// operation codes and the status struct of the pointer modulo unit.
// No dependencies.
package fcbf_pkg;

  // Parameter defaults
  localparam int unsigned CAPACITY_DEF = 4096;
  localparam int unsigned MAX_PEEK_DEF = 64;

  // Field widths fixed by the interface
  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned TOT_W  = 32;

  // Capacity register reset value
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_PEEK  = 3'd1,
    OP_POP   = 3'd2,
    OP_READ  = 3'd3,
    OP_END   = 3'd4
  } op_e;

  // Status of the iterative modulo unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

// ----- design/fcbf_if.sv -----
// Valid/ready channel interfaces for the byte FIFO: command in, result out.
// Depends on fcbf_pkg.
interface fcbf_in_if import fcbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] in_byte;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output op, output in_byte, output length, input ready);
  modport sink   (input valid, input op, input in_byte, input length, output ready);
endinterface

interface fcbf_out_if import fcbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              last;
  logic              accepted;
  logic [CNT_W-1:0]  buffered;
  logic [CNT_W-1:0]  remaining;
  logic [TOT_W-1:0]  written_total;
  logic [TOT_W-1:0]  read_total_out;
  logic              end_seen;
  logic              at_eof;

  modport source (
    output valid, output out_byte, output byte_valid, output last, output accepted,
    output buffered, output remaining, output written_total, output read_total_out,
    output end_seen, output at_eof, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input last, input accepted,
    input buffered, input remaining, input written_total, input read_total_out,
    input end_seen, input at_eof, output ready
  );
endinterface

// ----- design/fcbf_ram.sv -----
// Ring storage of the byte FIFO: one write port, one read port,
// registered read data. Depends on fcbf_pkg.
module fcbf_ram import fcbf_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fcbf_mod.sv -----
// Iterative remainder unit: dividend mod divisor, one dividend bit per cycle
// (restoring). Used to wrap ring pointers. Depends on fcbf_pkg.
module fcbf_mod import fcbf_pkg::*; #(
  parameter int unsigned SW = CNT_W + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SW-1:0]    dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output mod_stat_t        stat_o,
  output logic [CNT_W-1:0] rem_o
);

  localparam int unsigned IW = $clog2(SW + 1);

  logic [SW-1:0]    dvd_q, dvd_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [IW-1:0]    iter_q, iter_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             fits;

  // one shift-subtract step
  assign trial = {rem_q, dvd_q[SW-1]};
  assign fits  = (trial >= {1'b0, divisor_i});
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      iter_d = IW'(SW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd_d  = dvd_q << 1;
      iter_d = iter_q - IW'(1);
      if (iter_q == IW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      iter_q <= iter_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ----- design/flow_controlled_byte_fifo_top.sv -----
// Channel   Dir  Handshake        Payload
// in_i      in   valid/ready      op, in_byte, length
// out_o     out  valid/ready      out_byte, byte_valid, last, accepted, counts, flags
// cfg       in   cfg_we_i         cfg_wdata_i -> cap_q
//
// Write, pop, end and unknown ops: the result register is loaded as the command
// is taken when it is free or emptied that cycle. Peek and read of n bytes:
// one byte per cycle from the ring memory, whose read data is registered, while
// the result register takes them. A pointer sum at or beyond twice the capacity
// (only after the capacity was lowered) goes through the modulo unit, which
// holds the flow, also for the pointer left after the last byte of a read.
// Reset is asynchronous and needs no clearing pass; the ring is not cleared.
// A stalled result register holds; a new command is taken while it waits.
//
// Top level: sequencer, counters, pointers; instantiates fcbf_ram, fcbf_mod.
// Depends on fcbf_pkg, fcbf_if and the assertion macro header.
`include "flow_controlled_byte_fifo_top_defines.svh"

module flow_controlled_byte_fifo_top import fcbf_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned MAX_PEEK = MAX_PEEK_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  fcbf_in_if.sink          in_i,
  fcbf_out_if.source       out_o
);

  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam int unsigned NW = $clog2(MAX_PEEK + 1);
  localparam logic [CNT_W-1:0] CAP_CLAMP =
    (CAPACITY >= (1 << CNT_W)) ? {CNT_W{1'b1}} : CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] PEEK_LIM = CNT_W'(MAX_PEEK);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_ISSUE,
    S_STREAM,
    S_MOD
  } state_e;

  // where the modulo result goes
  typedef enum logic [1:0] {
    T_WP,
    T_RP_POP,
    T_RP_END,
    T_ADDR
  } tgt_e;

  state_e            state_q, state_d;
  tgt_e              tgt_q, tgt_d;
  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [PW-1:0]     wp_q, wp_d;
  logic [PW-1:0]     rp_q, rp_d;
  logic [PW-1:0]     addr_q, addr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TOT_W-1:0]  wt_q, wt_d;
  logic [TOT_W-1:0]  rt_q, rt_d;
  logic              ended_q, ended_d;
  logic [NW-1:0]     left_q, left_d;
  logic              rd_q, rd_d;
  logic              acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] ob_q;
  logic              obv_q, olast_q, oacc_q;
  logic [CNT_W-1:0]  obuf_q, orem_q;
  logic [TOT_W-1:0]  owt_q, ort_q;
  logic              oend_q, oeof_q;

  logic [CNT_W-1:0]  eff_cap;
  logic              full;
  logic              in_ready, in_fire, out_free;
  logic              out_i_ready_w;
  logic [CNT_W-1:0]  n_pop;
  logic [CNT_W-1:0]  peek_lim, n_pk13;
  logic [NW-1:0]     n_pk;

  logic [PW-1:0]     adv_base;
  logic [CNT_W-1:0]  adv_inc;
  logic [SW-1:0]     adv_sum;
  logic [SW:0]       adv_d1, adv_d2;
  logic              adv_fast;
  logic [PW-1:0]     adv_res;

  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              mod_start;
  mod_stat_t         mod_stat;
  logic [CNT_W-1:0]  mod_rem;

  logic              load_out;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_bvalid, ld_last, ld_acc;
  logic [CNT_W-1:0]  ld_rem;

  // effective capacity: zero acts as one, clamp to the ring size
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > CAPACITY) begin
      eff_cap = CAP_CLAMP;
    end else begin
      eff_cap = cap_q;
    end
  end

  assign full     = (cnt_q >= eff_cap);
  assign in_ready = (state_q == S_IDLE);
  assign in_fire  = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_i_ready_w;

  assign out_i_ready_w = out_o.ready;

  // request clamps
  assign n_pop    = (in_i.length > LEN_W'(cnt_q)) ? cnt_q : in_i.length[CNT_W-1:0];
  assign peek_lim = (cnt_q > PEEK_LIM) ? PEEK_LIM : cnt_q;
  assign n_pk13   = (in_i.length > LEN_W'(peek_lim)) ? peek_lim : in_i.length[CNT_W-1:0];
  assign n_pk     = n_pk13[NW-1:0];

  // pointer advance: fast when the sum stays below twice the capacity
  always_comb begin
    adv_base = addr_q;
    adv_inc  = CNT_W'(1);
    if (state_q == S_IDLE) begin
      if (in_i.op == OP_POP) begin
        adv_base = rp_q;
        adv_inc  = n_pop;
      end else begin
        adv_base = wp_q;
      end
    end
  end

  assign adv_sum  = SW'(adv_base) + SW'(adv_inc);
  assign adv_d1   = {1'b0, adv_sum} - (SW + 1)'(eff_cap);
  assign adv_d2   = {1'b0, adv_sum} - (SW + 1)'({eff_cap, 1'b0});
  assign adv_fast = adv_d2[SW];
  assign adv_res  = adv_d1[SW] ? adv_sum[PW-1:0] : adv_d1[PW-1:0];

  // sequencer and counters
  always_comb begin
    logic acc_now;
    logic res_now;
    logic res_slow;

    acc_now     = 1'b0;
    res_now     = 1'b0;
    res_slow    = 1'b0;
    state_d     = state_q;
    tgt_d       = tgt_q;
    cap_d       = cfg_we_i ? cfg_wdata_i : cap_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    wt_d        = wt_q;
    rt_d        = rt_q;
    ended_d     = ended_q;
    left_d      = left_q;
    rd_d        = rd_q;
    acc_d       = acc_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = addr_q;
    mod_start   = 1'b0;
    load_out    = 1'b0;
    ld_byte     = '0;
    ld_bvalid   = 1'b0;
    ld_last     = 1'b1;
    ld_acc      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.op)
            OP_WRITE: begin
              res_now = 1'b1;
              if (!full) begin
                acc_now = 1'b1;
                ram_we  = 1'b1;
                wt_d    = wt_q + TOT_W'(1);
                cnt_d   = cnt_q + CNT_W'(1);
                if (adv_fast) begin
                  wp_d = adv_res;
                end else begin
                  mod_start = 1'b1;
                  tgt_d     = T_WP;
                  res_slow  = 1'b1;
                end
              end
            end
            OP_POP: begin
              res_now = 1'b1;
              if (n_pop != '0) begin
                rt_d  = rt_q + TOT_W'(n_pop);
                cnt_d = cnt_q - n_pop;
                if (adv_fast) begin
                  rp_d = adv_res;
                end else begin
                  mod_start = 1'b1;
                  tgt_d     = T_RP_POP;
                  res_slow  = 1'b1;
                end
              end
            end
            OP_PEEK, OP_READ: begin
              if (n_pk == '0) begin
                res_now = 1'b1;
              end else begin
                if (in_i.op == OP_READ) begin
                  rt_d  = rt_q + TOT_W'(n_pk);
                  cnt_d = cnt_q - CNT_W'(n_pk);
                end
                rd_d      = (in_i.op == OP_READ);
                left_d    = n_pk;
                addr_d    = rp_q;
                ram_re    = 1'b1;
                ram_raddr = rp_q;
                state_d   = S_STREAM;
              end
            end
            OP_END: begin
              ended_d = 1'b1;
              res_now = 1'b1;
            end
            default: begin
              res_now = 1'b1;
            end
          endcase
          acc_d = acc_now;
          // single result: deliver now when possible
          if (res_now) begin
            if (res_slow) begin
              state_d = S_MOD;
            end else if (out_free) begin
              load_out = 1'b1;
              ld_acc   = acc_now;
            end else begin
              state_d = S_ONE;
            end
          end
        end
      end

      S_ONE: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_acc   = acc_q;
          state_d  = S_IDLE;
        end
      end

      S_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = addr_q;
        state_d   = S_STREAM;
      end

      S_STREAM: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_byte   = ram_rdata;
          ld_bvalid = 1'b1;
          ld_last   = (left_q == NW'(1));
          left_d    = left_q - NW'(1);
          if (left_q == NW'(1)) begin
            // read leaves the pointer one past the last byte
            if (rd_q && !adv_fast) begin
              mod_start = 1'b1;
              tgt_d     = T_RP_END;
              state_d   = S_MOD;
            end else begin
              if (rd_q) begin
                rp_d = adv_res;
              end
              state_d = S_IDLE;
            end
          end else if (adv_fast) begin
            addr_d    = adv_res;
            ram_re    = 1'b1;
            ram_raddr = adv_res;
          end else begin
            mod_start = 1'b1;
            tgt_d     = T_ADDR;
            state_d   = S_MOD;
          end
        end
      end

      S_MOD: begin
        if (mod_stat.done) begin
          case (tgt_q)
            T_WP: begin
              wp_d    = PW'(mod_rem);
              state_d = S_ONE;
            end
            T_RP_POP: begin
              rp_d    = PW'(mod_rem);
              state_d = S_ONE;
            end
            T_RP_END: begin
              rp_d    = PW'(mod_rem);
              state_d = S_IDLE;
            end
            T_ADDR: begin
              addr_d  = PW'(mod_rem);
              state_d = S_ISSUE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = load_out || (out_valid_q && !out_i_ready_w);
  end

  // free space after the step, zero once over capacity
  assign ld_rem = (cnt_d >= eff_cap) ? '0 : (eff_cap - cnt_d);

  // state, counters and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_q       <= T_WP;
      cap_q       <= CAP_RESET;
      wp_q        <= '0;
      rp_q        <= '0;
      addr_q      <= '0;
      cnt_q       <= '0;
      wt_q        <= '0;
      rt_q        <= '0;
      ended_q     <= 1'b0;
      left_q      <= '0;
      rd_q        <= 1'b0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      ob_q        <= '0;
      obv_q       <= 1'b0;
      olast_q     <= 1'b0;
      oacc_q      <= 1'b0;
      obuf_q      <= '0;
      orem_q      <= '0;
      owt_q       <= '0;
      ort_q       <= '0;
      oend_q      <= 1'b0;
      oeof_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      tgt_q       <= tgt_d;
      cap_q       <= cap_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      addr_q      <= addr_d;
      cnt_q       <= cnt_d;
      wt_q        <= wt_d;
      rt_q        <= rt_d;
      ended_q     <= ended_d;
      left_q      <= left_d;
      rd_q        <= rd_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      if (load_out) begin
        ob_q    <= ld_byte;
        obv_q   <= ld_bvalid;
        olast_q <= ld_last;
        oacc_q  <= ld_acc;
        obuf_q  <= cnt_d;
        orem_q  <= ld_rem;
        owt_q   <= wt_d;
        ort_q   <= rt_d;
        oend_q  <= ended_d;
        oeof_q  <= ended_d && (cnt_d == '0);
      end
    end
  end

  // ring memory: writes only on an accepted write command, reads only while
  // a peek or read streams, so the two never touch the same cycle
  fcbf_ram #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_i.in_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // pointer wrap for sums at or beyond twice the capacity
  fcbf_mod #(
    .SW (SW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (adv_sum),
    .divisor_i  (eff_cap),
    .stat_o     (mod_stat),
    .rem_o      (mod_rem)
  );

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = ob_q;
  assign out_o.byte_valid     = obv_q;
  assign out_o.last           = olast_q;
  assign out_o.accepted       = oacc_q;
  assign out_o.buffered       = obuf_q;
  assign out_o.remaining      = orem_q;
  assign out_o.written_total  = owt_q;
  assign out_o.read_total_out = ort_q;
  assign out_o.end_seen       = oend_q;
  assign out_o.at_eof         = oeof_q;

  `FCBF_ASSERT(a_cnt_matches_totals, cnt_q == CNT_W'(wt_q - rt_q), "fill count off totals")
  `FCBF_ASSERT(a_ptr_in_ring, (32'(wp_q) < CAPACITY) && (32'(rp_q) < CAPACITY), "pointer out of ring")
  `FCBF_ASSERT(a_mod_start_idle, !(mod_start && mod_stat.busy), "modulo unit restarted while busy")
  `FCBF_ASSERT(a_stream_left, (state_q != S_STREAM) || (left_q != '0), "stream with no bytes left")
  `FCBF_ASSERT_NEXT(a_write_counts, in_fire && (in_i.op == OP_WRITE) && !full, wt_q == $past(wt_q) + TOT_W'(1), "stored write not counted")

endmodule
